FILE: design/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types and constants for the page frame cache.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int FRAMES       = 16;
    localparam int FIDX_BITS    = $clog2(FRAMES);
    localparam int PAGE_ID_BITS = 24;
    localparam int PIN_BITS     = 8;
    localparam int QDEPTH       = 2;

    typedef logic [PIN_BITS-1:0] t_pins;

    typedef enum logic [1:0] {
        ACT_FETCH     = 2'd0,
        ACT_UNPIN     = 2'd1,
        ACT_FLUSH     = 2'd2,
        ACT_FLUSH_ALL = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_HIT        = 3'd0,
        ST_MISS_FREE  = 3'd1,
        ST_MISS_EVICT = 3'd2,
        ST_ALL_PINNED = 3'd3,
        ST_UNPINNED   = 3'd4,
        ST_NOT_RES    = 3'd5,
        ST_WRITTEN    = 3'd6,
        ST_CLEAN      = 3'd7
    } t_status;

    // classified item handed from front to back
    typedef struct packed {
        t_action                 action;
        logic [PAGE_ID_BITS-1:0] page_id;
        logic                    mark_dirty;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FLUSH,
        BK_TAIL
    } t_bk_state;

endpackage

FILE: design/pfc_front.sv
// ----------------------------------------------------------------------------
// pfc_front
// Takes items and buffers them in a short queue for the back end.
// ----------------------------------------------------------------------------
module pfc_front
    import pfc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [1:0]              i_action,
    input  logic [PAGE_ID_BITS-1:0] i_page_id,
    input  logic                    i_mark_dirty,
    output logic                    o_busy,
    output logic                    o_cmd_valid,
    output t_cmd                    o_cmd,
    input  logic                    i_cmd_pop
);

    localparam int QB = $clog2(QDEPTH);

    t_cmd            r_q [QDEPTH];
    logic [QB-1:0]   r_wp, r_rp;
    logic [QB:0]     r_cnt;
    logic            push;

    assign o_busy      = (r_cnt == (QB+1)'(QDEPTH));
    assign push        = i_start && !o_busy;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{action: t_action'(i_action), page_id: i_page_id,
                           mark_dirty: i_mark_dirty};
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push)      r_wp <= r_wp + 1'b1;
            if (i_cmd_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QB+1)'(push) - (QB+1)'(i_cmd_pop);
        end
    end

endmodule

FILE: design/pfc_back.sv
// ----------------------------------------------------------------------------
// pfc_back
// Frame table, LRU ranks and pin counts; executes one item at a time.
// ----------------------------------------------------------------------------
module pfc_back
    import pfc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cmd_valid,
    input  t_cmd                    i_cmd,
    output logic                    o_cmd_pop,
    output logic                    o_valid,
    output logic [2:0]              o_status,
    output logic [3:0]              o_frame,
    output logic                    o_read_needed,
    output logic                    o_write_back,
    output logic [23:0]             o_write_page,
    output logic                    o_last
);

    localparam logic [FIDX_BITS:0] FULL = (FIDX_BITS+1)'(FRAMES);
    localparam t_pins PIN_MAX = '1;

    logic [PAGE_ID_BITS-1:0] r_tag   [FRAMES];
    logic [FIDX_BITS-1:0]    r_rank  [FRAMES];
    t_pins                   r_pins  [FRAMES];
    logic [FRAMES-1:0]       r_valid, r_dirty;
    logic [FIDX_BITS:0]      r_next;

    t_bk_state               r_state, n_state;
    t_cmd                    r_cmd;
    logic [FIDX_BITS:0]      r_idx;      // scan position
    logic                    r_vfound;
    logic [FIDX_BITS-1:0]    r_vic, r_best;
    logic [4:0]              r_nout;     // flush-all results so far
    logic [23:0]             r_owp_hold; // write-back held for the next result

    // result register
    logic                    r_ov, r_ord, r_owb, r_olast;
    logic [2:0]              r_ost;
    logic [3:0]              r_ofr;
    logic [23:0]             r_owp;

    // lookup (parallel tag compare)
    logic [FRAMES-1:0]       hitv;
    logic                    hit;
    logic [FIDX_BITS-1:0]    hf;
    always_comb begin
        hf = '0;
        for (int i = 0; i < FRAMES; i++) begin
            hitv[i] = r_valid[i] && (r_tag[i] == i_cmd.page_id);
        end
        for (int i = FRAMES-1; i >= 0; i--) begin
            if (hitv[i]) hf = FIDX_BITS'(i);
        end
        hit = |hitv;
    end

    logic [FIDX_BITS-1:0] sidx;
    assign sidx = r_idx[FIDX_BITS-1:0];
    logic scan_end;
    assign scan_end = (r_idx == FULL - 1'b1);

    // which item is in the back end: accept in IDLE
    assign o_cmd_pop = (r_state == BK_IDLE) && i_cmd_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid && i_cmd.action == ACT_FETCH && !hit && r_next == FULL)
                    n_state = BK_SCAN;
                else if (i_cmd_valid && i_cmd.action == ACT_FLUSH_ALL)
                    n_state = BK_FLUSH;
            end
            BK_SCAN:  if (scan_end) n_state = BK_IDLE;
            BK_FLUSH: if (scan_end) n_state = BK_TAIL;
            BK_TAIL:  n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        logic [FIDX_BITS:0]   oldr;
        logic                 vnew;
        logic                 emitf;
        logic [FIDX_BITS-1:0] v;
        oldr  = '0;
        vnew  = 1'b0;
        emitf = 1'b0;
        v     = '0;
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_valid <= '0;
            r_dirty <= '0;
            r_next  <= '0;
            r_ov    <= 1'b0;
            for (int i = 0; i < FRAMES; i++) r_pins[i] <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= 1'b0;
            r_ord   <= 1'b0;
            r_owb   <= 1'b0;
            r_owp   <= '0;
            r_olast <= 1'b1;
            r_ofr   <= '0;
            case (r_state)
                BK_IDLE: begin
                    r_cmd    <= i_cmd;
                    r_idx    <= '0;
                    r_vfound <= 1'b0;
                    r_nout   <= '0;
                    if (i_cmd_valid) begin
                        case (i_cmd.action)
                            ACT_FETCH: begin
                                if (hit) begin
                                    if (r_pins[hf] != PIN_MAX) r_pins[hf] <= r_pins[hf] + 1'b1;
                                    for (int i = 0; i < FRAMES; i++)
                                        if (r_valid[i] && r_rank[i] < r_rank[hf])
                                            r_rank[i] <= r_rank[i] + 1'b1;
                                    r_rank[hf] <= '0;
                                    r_ov  <= 1'b1;
                                    r_ost <= ST_HIT;
                                    r_ofr <= 4'(hf);
                                end else if (r_next != FULL) begin
                                    r_tag[r_next[FIDX_BITS-1:0]]   <= i_cmd.page_id;
                                    r_valid[r_next[FIDX_BITS-1:0]] <= 1'b1;
                                    r_pins[r_next[FIDX_BITS-1:0]]  <= t_pins'(1);
                                    r_dirty[r_next[FIDX_BITS-1:0]] <= 1'b0;
                                    for (int i = 0; i < FRAMES; i++)
                                        if (r_valid[i]) r_rank[i] <= r_rank[i] + 1'b1;
                                    r_rank[r_next[FIDX_BITS-1:0]] <= '0;
                                    r_next <= r_next + 1'b1;
                                    r_ov  <= 1'b1;
                                    r_ost <= ST_MISS_FREE;
                                    r_ofr <= 4'(r_next);
                                    r_ord <= 1'b1;
                                end
                            end
                            ACT_UNPIN: begin
                                r_ov <= 1'b1;
                                if (hit) begin
                                    if (i_cmd.mark_dirty) r_dirty[hf] <= 1'b1;
                                    if (r_pins[hf] != '0) r_pins[hf] <= r_pins[hf] - 1'b1;
                                    r_ost <= ST_UNPINNED;
                                    r_ofr <= 4'(hf);
                                end else r_ost <= ST_NOT_RES;
                            end
                            ACT_FLUSH: begin
                                r_ov <= 1'b1;
                                if (!hit) r_ost <= ST_NOT_RES;
                                else if (r_dirty[hf]) begin
                                    r_dirty[hf] <= 1'b0;
                                    r_ost <= ST_WRITTEN;
                                    r_ofr <= 4'(hf);
                                    r_owb <= 1'b1;
                                    r_owp <= 24'(i_cmd.page_id);
                                end else begin
                                    r_ost <= ST_CLEAN;
                                    r_ofr <= 4'(hf);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                BK_SCAN: begin
                    // one frame a cycle: oldest unpinned
                    if (r_valid[sidx] && r_pins[sidx] == '0 &&
                        (!r_vfound || r_rank[sidx] > r_best)) begin
                        vnew = 1'b1;
                    end
                    if (vnew) begin
                        r_vfound <= 1'b1;
                        r_vic    <= sidx;
                        r_best   <= r_rank[sidx];
                    end
                    r_idx <= r_idx + 1'b1;
                    if (scan_end) begin
                        r_ov <= 1'b1;
                        if (!r_vfound && !vnew) r_ost <= ST_ALL_PINNED;
                        else begin
                            v    = vnew ? sidx : r_vic;
                            oldr = {1'b0, vnew ? r_rank[sidx] : r_best};
                            r_ost <= ST_MISS_EVICT;
                            r_ofr <= 4'(v);
                            r_ord <= 1'b1;
                            r_owb <= r_dirty[v];
                            r_owp <= r_dirty[v] ? 24'(r_tag[v]) : '0;
                            r_tag[v]   <= r_cmd.page_id;
                            r_pins[v]  <= t_pins'(1);
                            r_dirty[v] <= 1'b0;
                            for (int i = 0; i < FRAMES; i++)
                                if (r_valid[i] && {1'b0, r_rank[i]} < oldr)
                                    r_rank[i] <= r_rank[i] + 1'b1;
                            r_rank[v] <= '0;
                        end
                    end
                end
                BK_FLUSH: begin
                    // frame order; the bound of sixteen results is never hit
                    // beyond FRAMES, since at most one per frame
                    r_idx <= r_idx + 1'b1;
                    emitf = r_valid[sidx] && r_dirty[sidx] && (r_nout != 5'd16);
                    if (emitf) begin
                        r_dirty[sidx] <= 1'b0;
                        r_nout <= r_nout + 1'b1;
                    end
                    // hold one write-back so "last" can be set on the final one
                    if (emitf && r_nout != '0) begin
                        r_ov <= 1'b1;
                        r_olast <= 1'b0;
                        r_ost <= ST_WRITTEN;
                        r_ofr <= 4'(r_vic);
                        r_owb <= 1'b1;
                        r_owp <= r_owp_hold;
                    end
                    if (emitf) begin
                        r_vic <= sidx;
                        r_owp_hold <= 24'(r_tag[sidx]);
                    end
                end
                BK_TAIL: begin
                    // flush-all tail: held write-back, or one clean result
                    r_ov    <= 1'b1;
                    r_olast <= 1'b1;
                    if (r_nout == '0) begin
                        r_ost <= ST_CLEAN;
                        r_ofr <= '0;
                    end else begin
                        r_ost <= ST_WRITTEN;
                        r_ofr <= 4'(r_vic);
                        r_owb <= 1'b1;
                        r_owp <= r_owp_hold;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid       = r_ov;
    assign o_status      = r_ost;
    assign o_frame       = r_ofr;
    assign o_read_needed = r_ord;
    assign o_write_back  = r_owb;
    assign o_write_page  = r_owp;
    assign o_last        = r_olast;

endmodule

FILE: design/page_frame_cache_lru_pin_unit.sv
// ----------------------------------------------------------------------------
// page_frame_cache_lru_pin_unit
// Page buffer pool frame manager: LRU replacement with pin counts.
// ----------------------------------------------------------------------------
// Results are strobed on o_valid for one cycle and cannot be stalled. Hits,
// fills into unused frames, unpin and flush of one page are queued, then
// answered from the result register once the back end is idle. A miss with
// every frame in use walks all FRAMES frames, one per cycle, to find the
// least recently used unpinned frame. Flush-all walks the frames in index
// order too and emits its write-backs as it goes, the final one (or a single
// clean result) from the tail state after the walk ends. A two-entry queue
// between the command front end and the frame-table back end takes new items
// while one is being worked on; busy is high only while that queue is full.
// ----------------------------------------------------------------------------
module page_frame_cache_lru_pin_unit
    import pfc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_action,
    input  logic [PAGE_ID_BITS-1:0] i_page_id,
    input  logic                    i_mark_dirty,
    output logic                    o_valid,
    output logic [2:0]              o_status,
    output logic [3:0]              o_frame,
    output logic                    o_read_needed,
    output logic                    o_write_back,
    output logic [23:0]             o_write_page,
    output logic                    o_last
);

    logic cmd_valid, cmd_pop;
    t_cmd cmd;

    pfc_front u_front (
        .i_clk, .i_rst_n, .i_start(start), .i_action, .i_page_id, .i_mark_dirty,
        .o_busy(busy), .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_pop(cmd_pop)
    );

    pfc_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .i_cmd(cmd), .o_cmd_pop(cmd_pop),
        .o_valid, .o_status, .o_frame, .o_read_needed, .o_write_back,
        .o_write_page, .o_last
    );

endmodule

FILE: verif/page_frame_cache_lru_pin_unit_test.sv
// ----------------------------------------------------------------------------
// page_frame_cache_lru_pin_unit_test
// Self-checking bench for the page frame cache: a queue-fed command driver,
// a result monitor and a frame-table predictor with LRU and pin counts.
// ----------------------------------------------------------------------------
module page_frame_cache_lru_pin_unit_test;
    import pfc_pkg::*;

    typedef struct packed {
        t_action                 action;
        logic [PAGE_ID_BITS-1:0] page_id;
        logic                    mark_dirty;
    } t_req;

    typedef struct packed {
        t_status                 status;
        logic [3:0]              frame;
        logic                    read_needed;
        logic                    write_back;
        logic [23:0]             write_page;
        logic                    last;
    } t_res;

    localparam logic [PIN_BITS-1:0] PIN_SAT = {PIN_BITS{1'b1}};

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [1:0]              i_action;
    logic [PAGE_ID_BITS-1:0] i_page_id;
    logic                    i_mark_dirty;
    logic                    o_valid;
    logic [2:0]              o_status;
    logic [3:0]              o_frame;
    logic                    o_read_needed;
    logic                    o_write_back;
    logic [23:0]             o_write_page;
    logic                    o_last;

    page_frame_cache_lru_pin_unit i_dut (.*);

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // predictor copy of the frame table
    logic [PAGE_ID_BITS-1:0] pool_tag   [FRAMES];
    logic                    pool_valid [FRAMES];
    logic [PIN_BITS-1:0]     pool_pins  [FRAMES];
    logic                    pool_dirty [FRAMES];
    int unsigned             pool_rank  [FRAMES];
    int unsigned             pool_filled;

    t_req pending_reqs[$];
    t_res expected_results[$];
    int   err_cnt;
    int   accepted_cnt;
    int   result_cnt;
    int   evict_cnt;
    int   pinned_out_cnt;
    bit   drain_req;     // sender holds off until all results arrive

    function automatic int lookup_frame(logic [PAGE_ID_BITS-1:0] pid);
        for (int i = 0; i < FRAMES; i++)
            if (pool_valid[i] && pool_tag[i] == pid) return i;
        return -1;
    endfunction

    function automatic void make_recent(int f, int unsigned old_rank);
        for (int i = 0; i < FRAMES; i++)
            if (i != f && pool_valid[i] && pool_rank[i] < old_rank) pool_rank[i]++;
        pool_rank[f] = 0;
    endfunction

    function automatic t_res mk_res(t_status s, int f, bit rd, bit wb,
                                    logic [23:0] wp, bit lst);
        t_res r;
        r.status = s; r.frame = f[3:0]; r.read_needed = rd;
        r.write_back = wb; r.write_page = wp; r.last = lst;
        return r;
    endfunction

    function automatic void expect_res(t_res r);
        expected_results = {expected_results, r};
    endfunction

    // apply one request to the table and queue what it should produce
    function automatic void predict_request(t_req q);
        int f;
        int victim;
        int unsigned best;
        int n;
        f = lookup_frame(q.page_id);
        case (q.action)
            ACT_FETCH: begin
                if (f >= 0) begin
                    if (pool_pins[f] != PIN_SAT) pool_pins[f]++;
                    make_recent(f, pool_rank[f]);
                    expect_res(mk_res(ST_HIT, f, 0, 0, 0, 1));
                end else if (pool_filled < FRAMES) begin
                    f = pool_filled;
                    pool_filled++;
                    pool_tag[f] = q.page_id; pool_valid[f] = 1;
                    pool_pins[f] = 1; pool_dirty[f] = 0;
                    make_recent(f, f);
                    expect_res(mk_res(ST_MISS_FREE, f, 1, 0, 0, 1));
                end else begin
                    victim = -1; best = 0;
                    for (int i = 0; i < FRAMES; i++)
                        if (pool_valid[i] && pool_pins[i] == 0 &&
                            (victim < 0 || pool_rank[i] > best)) begin
                            victim = i; best = pool_rank[i];
                        end
                    if (victim < 0) begin
                        pinned_out_cnt++;
                        expect_res(mk_res(ST_ALL_PINNED, 0, 0, 0, 0, 1));
                    end else begin
                        evict_cnt++;
                        expect_res(mk_res(ST_MISS_EVICT, victim, 1,
                            pool_dirty[victim],
                            pool_dirty[victim] ? pool_tag[victim] : 24'd0, 1));
                        pool_tag[victim] = q.page_id; pool_pins[victim] = 1;
                        pool_dirty[victim] = 0;
                        make_recent(victim, best);
                    end
                end
            end
            ACT_UNPIN: begin
                if (f < 0) begin
                    expect_res(mk_res(ST_NOT_RES, 0, 0, 0, 0, 1));
                end else begin
                    if (q.mark_dirty) pool_dirty[f] = 1;
                    if (pool_pins[f] != 0) pool_pins[f]--;
                    expect_res(mk_res(ST_UNPINNED, f, 0, 0, 0, 1));
                end
            end
            ACT_FLUSH: begin
                if (f < 0) begin
                    expect_res(mk_res(ST_NOT_RES, 0, 0, 0, 0, 1));
                end else if (pool_dirty[f]) begin
                    pool_dirty[f] = 0;
                    expect_res(mk_res(ST_WRITTEN, f, 0, 1, q.page_id, 1));
                end else begin
                    expect_res(mk_res(ST_CLEAN, f, 0, 0, 0, 1));
                end
            end
            default: begin
                n = 0;
                for (int i = 0; i < FRAMES; i++)
                    if (pool_valid[i] && pool_dirty[i]) begin
                        pool_dirty[i] = 0;
                        expect_res(mk_res(ST_WRITTEN, i, 0, 1, pool_tag[i], 0));
                        n++;
                    end
                if (n == 0) expect_res(mk_res(ST_CLEAN, 0, 0, 0, 0, 1));
                else expected_results[$].last = 1'b1;
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- driver
    int gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left <= $urandom_range(0, 12);
        end else begin
            if (start && !busy) begin
                predict_request({t_action'(i_action), i_page_id, i_mark_dirty});
                accepted_cnt++;
            end
            if (start && busy) begin
                // hold current item
            end else if (gap_left > 0) begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_reqs.size() == 0) begin
                start <= 1'b0;
            end else if (drain_req && (expected_results.size() != 0 ||
                         (start && !busy))) begin
                start <= 1'b0;
            end else begin
                t_req q;
                q = pending_reqs[0];
                pending_reqs.delete(0);
                start <= 1'b1;
                i_action <= q.action;
                i_page_id <= q.page_id;
                i_mark_dirty <= q.mark_dirty;
                drain_req <= 1'b0;
                // stretches without gaps in part of every 60 accepted items
                gap_left <= (accepted_cnt % 60 > 40) ? 0 : $urandom_range(0, 12);
            end
        end
    end

    // --------------------------------------------------------------- monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            t_res e;
            result_cnt++;
            if (expected_results.size() == 0) begin
                $error("unexpected result status=%0d frame=%0d", o_status, o_frame);
                err_cnt++;
            end else begin
                e = expected_results[0];
                expected_results.delete(0);
                if (o_status !== e.status) begin
                    $error("status exp=%0d act=%0d", e.status, o_status); err_cnt++;
                end
                if (o_frame !== e.frame) begin
                    $error("frame exp=%0d act=%0d", e.frame, o_frame); err_cnt++;
                end
                if (o_read_needed !== e.read_needed) begin
                    $error("read_needed exp=%0d act=%0d", e.read_needed, o_read_needed);
                    err_cnt++;
                end
                if (o_write_back !== e.write_back) begin
                    $error("write_back exp=%0d act=%0d", e.write_back, o_write_back);
                    err_cnt++;
                end
                if (o_write_page !== e.write_page) begin
                    $error("write_page exp=%h act=%h", e.write_page, o_write_page);
                    err_cnt++;
                end
                if (o_last !== e.last) begin
                    $error("last exp=%0d act=%0d", e.last, o_last); err_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------- stimulus
    function automatic void add_req(t_action a, logic [PAGE_ID_BITS-1:0] p, bit d);
        t_req q;
        q.action = a; q.page_id = p; q.mark_dirty = d;
        pending_reqs = {pending_reqs, q};
    endfunction

    // a page from a small working set, with extreme ids mixed in
    function automatic logic [PAGE_ID_BITS-1:0] pick_page();
        int k;
        k = $urandom_range(0, 27);
        if (k == 26) return '1;
        if (k == 27) return PAGE_ID_BITS'($urandom());
        return {$urandom_range(0, 1) ? 4'hA : 4'h5, 16'h0, k[3:0]} ^ {20'h0, k[4], 3'b0};
    endfunction

    initial begin
        logic [PAGE_ID_BITS-1:0] pg;
        for (int i = 0; i < FRAMES; i++) begin
            pool_valid[i] = 0; pool_pins[i] = 0; pool_dirty[i] = 0;
            pool_tag[i] = 0; pool_rank[i] = 0;
        end
        pool_filled = 0;
        err_cnt = 0; accepted_cnt = 0; result_cnt = 0;
        evict_cnt = 0; pinned_out_cnt = 0;
        drain_req = 0;
        start = 0; i_action = ACT_FETCH; i_page_id = 0; i_mark_dirty = 0;
        i_rst_n = 1'b0;

        // directed: empty-pool corners, fill, hit, all pinned
        add_req(ACT_FLUSH_ALL, '0, 1'b0);          // nothing dirty
        add_req(ACT_UNPIN, 24'hFFFFFF, 1'b1);      // not resident
        add_req(ACT_FLUSH, 24'h000000, 1'b0);      // not resident
        add_req(ACT_FETCH, 24'h000000, 1'b0);
        add_req(ACT_FETCH, 24'hFFFFFF, 1'b0);
        add_req(ACT_FLUSH, 24'hFFFFFF, 1'b0);      // clean resident
        add_req(ACT_UNPIN, 24'hFFFFFF, 1'b1);
        add_req(ACT_UNPIN, 24'hFFFFFF, 1'b0);      // unpin at zero
        add_req(ACT_FLUSH, 24'hFFFFFF, 1'b1);      // written back
        add_req(ACT_FETCH, 24'h000000, 1'b0);      // hit, pinned twice
        for (int i = 2; i < FRAMES; i++)
            add_req(ACT_FETCH, 24'h555000 + 24'(i), 1'b0);
        add_req(ACT_FETCH, 24'h123456, 1'b0);      // evict clean unpinned frame 1
        add_req(ACT_FETCH, 24'h654321, 1'b0);      // all pinned
        for (int i = 0; i < FRAMES; i++)
            add_req(ACT_UNPIN, 24'h555000 + 24'(i), 1'b1);
        add_req(ACT_FETCH, 24'hAAAAAA, 1'b0);      // evict dirty victim
        add_req(ACT_FLUSH_ALL, '0, 1'b0);          // many write-backs

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // random: fetch/unpin pairs dominate so eviction keeps happening
        for (int n = 0; n < 166; n++) begin
            pg = pick_page();
            case ($urandom_range(0, 9))
                0, 1, 2, 3: add_req(ACT_FETCH, pg, 1'($urandom_range(0, 1)));
                4, 5, 6:    add_req(ACT_UNPIN, pg, 1'($urandom_range(0, 1)));
                7, 8:       add_req(ACT_FLUSH, pg, 1'($urandom_range(0, 1)));
                default:    add_req(ACT_FLUSH_ALL, PAGE_ID_BITS'($urandom()),
                                    1'($urandom_range(0, 1)));
            endcase
            if (n == 100) begin
                wait (pending_reqs.size() == 0);
                @(negedge i_clk);
                drain_req = 1'b1;
            end
        end

        do @(negedge i_clk); while (pending_reqs.size() != 0 || start);
        do @(negedge i_clk); while (expected_results.size() != 0);
        repeat (FRAMES * 4) @(posedge i_clk);

        $display("Covered %0d requests, %0d results, %0d evictions, %0d all-pinned misses.",
                 accepted_cnt, result_cnt, evict_cnt, pinned_out_cnt);
        if (err_cnt == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
